/* design/gamma_ramp_entry_assert.svh */
// ---------------------------------------------------------------------------
// gamma_ramp_entry_assert.svh
// Assertion macros for the gamma ramp entry block.
// ---------------------------------------------------------------------------
`ifndef GAMMA_RAMP_ENTRY_ASSERT_SVH
`define GAMMA_RAMP_ENTRY_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GRE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("gre assertion failed");
// next-cycle implication
`define GRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("gre assertion failed");
`else
`define GRE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* design/gre_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gre_pkg
// Types, widths and elaboration-time constant functions for the ramp block.
// ---------------------------------------------------------------------------
package gre_pkg;

	localparam int LOG_FRAC = 20;
	localparam int P_W      = 5;
	localparam int LG_W     = P_W + LOG_FRAC;
	localparam int GAMMA_W  = 16;
	localparam int GFRAC_W  = 12;
	localparam int DVD_W    = LG_W + GFRAC_W;
	localparam int Q_W      = DVD_W - LOG_FRAC;
	localparam int M_W      = 31;
	localparam int ACC_W    = 33;
	localparam int COEF_W   = 32;
	localparam int VAL_W    = 16;

	localparam logic [VAL_W-1:0]   FULL_SCALE = 16'd65280;
	localparam logic [GAMMA_W-1:0] GAMMA_ONE  = 16'd4096;
	localparam logic [Q_W-1:0]     EXP_CUT    = 17'd40;

	// byte address of the gamma register
	localparam logic [2:0]         ADDR_GAMMA = 3'd0;

	typedef struct packed {
		logic                zero;
		logic                sat;
		logic                use_orig;
		logic [P_W-1:0]      p;
		logic [M_W-1:0]      m;
		logic [LOG_FRAC-1:0] frac;
	} log_tok_t;

	typedef struct packed {
		logic               zero;
		logic               sat;
		logic [GAMMA_W-1:0] rem;
		logic [DVD_W-1:0]   wq;
	} div_tok_t;

	typedef struct packed {
		logic                zero;
		logic                sat;
		logic [ACC_W-1:0]    acc;
		logic [LOG_FRAC-1:0] f;
		logic [Q_W-1:0]      q;
	} exp_tok_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = x;
		res = 64'd0;
		for (int i = 31; i >= 0; i--) begin
			b = 64'd1 << (2 * i);
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// coefficient of exp step k: about 2^32 * 2^(-2^-k)
	function automatic logic [COEF_W-1:0] exp_coef(input int k);
		logic [63:0] c;
		c = 64'h8000_0000;
		for (int i = 1; i <= k; i++) begin
			c = isqrt64(c << 32);
		end
		return c[COEF_W-1:0];
	endfunction

	// log2 in p.LOG_FRAC form of a fixed value
	function automatic logic [LG_W-1:0] lg_fixed(input logic [31:0] v);
		logic [63:0]         m;
		logic [P_W-1:0]      p;
		logic [LOG_FRAC-1:0] frac;
		p    = '0;
		frac = '0;
		for (int i = 0; i < 17; i++) begin
			if (v[i]) begin
				p = P_W'(i);
			end
		end
		m = {32'd0, v} << (30 - p);
		for (int k = 0; k < LOG_FRAC; k++) begin
			m    = (m * m) >> 30;
			frac = {frac[LOG_FRAC-2:0], 1'b0};
			if (m >= 64'h8000_0000) begin
				frac[0] = 1'b1;
				m       = m >> 1;
			end
		end
		return {p, frac};
	endfunction

endpackage

/* design/gre_log_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gre_log_cell
// One log2 fraction bit: square the mantissa, renormalise, shift the bit in.
// ---------------------------------------------------------------------------
module gre_log_cell import gre_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  log_tok_t in_tok,
	output logic     out_valid,
	output log_tok_t out_tok
);

	logic [2*M_W-1:0] sq;
	logic [M_W:0]     sq_top;
	log_tok_t         nxt;

	always_comb begin
		sq     = {{M_W{1'b0}}, in_tok.m} * {{M_W{1'b0}}, in_tok.m};
		sq_top = sq[2*M_W-1:M_W-1];
		nxt    = in_tok;
		nxt.frac = {in_tok.frac[LOG_FRAC-2:0], sq_top[M_W]};
		nxt.m    = sq_top[M_W] ? sq_top[M_W:1] : sq_top[M_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_tok <= nxt;
	end

endmodule

/* design/gre_div_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gre_div_cell
// One restoring-division step: shift a dividend bit in, trial subtract.
// ---------------------------------------------------------------------------
module gre_div_cell import gre_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [GAMMA_W-1:0] gamma,
	input  logic               in_valid,
	input  div_tok_t           in_tok,
	output logic               out_valid,
	output div_tok_t           out_tok
);

	logic [GAMMA_W:0] trial;
	logic             ge;
	div_tok_t         nxt;

	always_comb begin
		trial   = {in_tok.rem, in_tok.wq[DVD_W-1]};
		ge      = trial >= {1'b0, gamma};
		nxt     = in_tok;
		nxt.rem = ge ? GAMMA_W'(trial - {1'b0, gamma}) : trial[GAMMA_W-1:0];
		nxt.wq  = {in_tok.wq[DVD_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_tok <= nxt;
	end

endmodule

/* design/gre_exp_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gre_exp_cell
// One exp2 step: scale the accumulator by this step's root when its bit is set.
// ---------------------------------------------------------------------------
module gre_exp_cell import gre_pkg::*; #(
	parameter int STEP = 1
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  exp_tok_t in_tok,
	output logic     out_valid,
	output exp_tok_t out_tok
);

	localparam logic [COEF_W-1:0] COEF = exp_coef(STEP);

	logic [ACC_W+COEF_W-1:0] prod;
	exp_tok_t                nxt;

	always_comb begin
		prod  = {{COEF_W{1'b0}}, in_tok.acc} * {{ACC_W{1'b0}}, COEF};
		nxt   = in_tok;
		nxt.f = {in_tok.f[LOG_FRAC-2:0], 1'b0};
		if (in_tok.f[LOG_FRAC-1]) begin
			nxt.acc = prod[ACC_W+COEF_W-1:COEF_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_tok <= nxt;
	end

endmodule

/* design/gamma_ramp_entry.sv */
`timescale 1ns / 1ps
// Throughput: one item per cycle; busy stays low, every stage is a register in a chain.
// Stages in order: front, 20 log cells, 37 divide cells, 20 exp cells, shift, output.
// Reset clears all stage valid bits and sets gamma to 1.0; no result is lost to stalls.
// ---------------------------------------------------------------------------
// gamma_ramp_entry
// Power-law ramp entry: 65280 * min(1, x^(1/gamma)) through log, divide and exp
// chains; log and divide cells are identical, each exp cell holds its own root.
// ---------------------------------------------------------------------------
module gamma_ramp_entry import gre_pkg::*; #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  entry_index,
	input  logic [15:0] original_value,
	input  logic        use_original,
	output logic        strobe,
	output logic [15:0] ramp_value,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "gamma_ramp_entry_assert.svh"

	localparam int DIV_STEPS = DVD_W;
	localparam int LATENCY   = 3 + 2 * LOG_FRAC + DIV_STEPS;

	// log2 of both possible denominators is fixed at elaboration
	localparam logic [VAL_W-1:0] DEN_IDX = VAL_W'(TABLE_ENTRIES - 1);
	localparam logic [LG_W-1:0]  LG_IDX  = lg_fixed(32'(TABLE_ENTRIES - 1));
	localparam logic [LG_W-1:0]  LG_FULL = lg_fixed({16'd0, FULL_SCALE});

	// -----------------------------------------------------------------------
	// Configuration: one register, gamma in Q4.12 at byte address 0
	// -----------------------------------------------------------------------
	logic [GAMMA_W-1:0] gamma_q;
	logic [GAMMA_W-1:0] gamma_eff;

	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_ONE;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			gamma_q <= pwdata[GAMMA_W-1:0];
		end
	end

	assign prdata    = paddr[2] ? 32'd0 : {16'd0, gamma_q};
	// a zero gamma behaves as 1.0
	assign gamma_eff = (gamma_q == '0) ? GAMMA_ONE : gamma_q;

	// -----------------------------------------------------------------------
	// Front stage: pick the base, flag the trivial cases, normalise the numerator
	// -----------------------------------------------------------------------
	logic [VAL_W-1:0] num;
	logic [VAL_W-1:0] den;
	logic [P_W-1:0]   lod_p;
	log_tok_t         front;
	logic             front_v_s1;
	log_tok_t         front_s1;

	always_comb begin
		num   = use_original ? original_value : {8'd0, entry_index};
		den   = use_original ? FULL_SCALE : DEN_IDX;
		lod_p = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (num[i]) begin
				lod_p = P_W'(i);
			end
		end
		front.zero     = (num == '0);
		front.sat      = (num != '0) && (num >= den);
		front.use_orig = use_original;
		front.p        = lod_p;
		front.m        = {{(M_W-VAL_W){1'b0}}, num} << (5'd30 - lod_p);
		front.frac     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_v_s1 <= 1'b0;
		end else begin
			front_v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		front_s1 <= front;
	end

	// -----------------------------------------------------------------------
	// Log chain: one fraction bit per cell
	// -----------------------------------------------------------------------
	logic [LOG_FRAC:0] log_v;
	log_tok_t          log_t [LOG_FRAC+1];

	assign log_v[0] = front_v_s1;
	assign log_t[0] = front_s1;

	for (genvar k = 0; k < LOG_FRAC; k++) begin : g_log
		gre_log_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (log_v[k]),
			.in_tok   (log_t[k]),
			.out_valid(log_v[k+1]),
			.out_tok  (log_t[k+1])
		);
	end

	// -----------------------------------------------------------------------
	// Divide chain: log ratio << 12 over gamma, one quotient bit per cell
	// -----------------------------------------------------------------------
	log_tok_t          log_end;
	logic [LG_W-1:0]   lg_ratio;
	logic [DIV_STEPS:0] div_v;
	div_tok_t          div_t [DIV_STEPS+1];

	assign log_end  = log_t[LOG_FRAC];
	assign lg_ratio = (log_end.use_orig ? LG_FULL : LG_IDX) - {log_end.p, log_end.frac};

	assign div_v[0]      = log_v[LOG_FRAC];
	assign div_t[0].zero = log_end.zero;
	assign div_t[0].sat  = log_end.sat;
	assign div_t[0].rem  = '0;
	assign div_t[0].wq   = {lg_ratio, {GFRAC_W{1'b0}}};

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		gre_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.gamma    (gamma_eff),
			.in_valid (div_v[k]),
			.in_tok   (div_t[k]),
			.out_valid(div_v[k+1]),
			.out_tok  (div_t[k+1])
		);
	end

	// -----------------------------------------------------------------------
	// Exp chain: 2^-fraction as a product of stored roots
	// -----------------------------------------------------------------------
	logic [LOG_FRAC:0] exp_v;
	exp_tok_t          exp_t [LOG_FRAC+1];

	assign exp_v[0]      = div_v[DIV_STEPS];
	assign exp_t[0].zero = div_t[DIV_STEPS].zero;
	assign exp_t[0].sat  = div_t[DIV_STEPS].sat;
	assign exp_t[0].acc  = {1'b1, {(ACC_W-1){1'b0}}};
	assign exp_t[0].f    = div_t[DIV_STEPS].wq[LOG_FRAC-1:0];
	assign exp_t[0].q    = div_t[DIV_STEPS].wq[DVD_W-1:LOG_FRAC];

	for (genvar k = 0; k < LOG_FRAC; k++) begin : g_exp
		gre_exp_cell #(
			.STEP(k + 1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (exp_v[k]),
			.in_tok   (exp_t[k]),
			.out_valid(exp_v[k+1]),
			.out_tok  (exp_t[k+1])
		);
	end

	// -----------------------------------------------------------------------
	// Shift by the integer part, then scale to full scale and clamp
	// -----------------------------------------------------------------------
	exp_tok_t         exp_end;
	logic             sh_v_s1;
	logic             sh_zero_s1;
	logic             sh_sat_s1;
	logic [ACC_W-1:0] sh_acc_s1;
	logic [ACC_W+VAL_W-1:0] scaled;
	logic [VAL_W:0]   scaled_top;
	logic [VAL_W-1:0] ramp_nxt;

	assign exp_end = exp_t[LOG_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_v_s1 <= 1'b0;
		end else begin
			sh_v_s1 <= exp_v[LOG_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		sh_zero_s1 <= exp_end.zero;
		sh_sat_s1  <= exp_end.sat;
		// drop everything once the shift reaches the cut-off
		sh_acc_s1  <= (exp_end.q >= EXP_CUT) ? '0 : (exp_end.acc >> exp_end.q[5:0]);
	end

	always_comb begin
		scaled     = {{VAL_W{1'b0}}, sh_acc_s1} * {{ACC_W{1'b0}}, FULL_SCALE};
		scaled_top = scaled[ACC_W+VAL_W-1:32];
		if (sh_zero_s1) begin
			ramp_nxt = '0;
		end else if (sh_sat_s1 || (scaled_top > {1'b0, FULL_SCALE})) begin
			ramp_nxt = FULL_SCALE;
		end else begin
			ramp_nxt = scaled_top[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= sh_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ramp_value <= ramp_nxt;
	end

	// -----------------------------------------------------------------------
	// Checks
	// -----------------------------------------------------------------------
	`GRE_ASSERT_IMP(a_out_range, clk, arst_n, strobe, ramp_value <= FULL_SCALE)
	`GRE_ASSERT_IMP(a_out_latency, clk, arst_n, strobe, $past(start, LATENCY))
	`GRE_ASSERT_NEXT(a_zero_base, clk, arst_n, sh_v_s1 && sh_zero_s1, strobe && ramp_value == '0)
	`GRE_ASSERT_NEXT(a_sat_base, clk, arst_n, sh_v_s1 && sh_sat_s1, strobe && ramp_value == FULL_SCALE)

endmodule
